// ===== hw/rtl/didtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// didtm_pkg: shared types and constants
// field widths, wildcard codes and the token handed along the match chain
// ----------------------------------------------------------------------------
package didtm_pkg;

	localparam int unsigned ENTRY_INDEX_W       = 4;
	localparam int unsigned ID_W                = 16;
	localparam int unsigned CLASS_W             = 24;
	localparam int unsigned BYTE_W              = 8;
	localparam int unsigned DEFAULT_TABLE_DEPTH = 16;

	localparam logic [ID_W-1:0]    ANY_ID    = 16'hFFFF;
	localparam logic [ID_W-1:0]    NULL_ID   = '0;
	localparam logic [CLASS_W-1:0] ANY_CLASS = '0;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	typedef struct packed {
		logic [ID_W-1:0]    vendor;
		logic [ID_W-1:0]    device;
		logic [CLASS_W-1:0] cls;
	} entry_t;

	// query travelling down the chain, with its running outcome
	typedef struct packed {
		logic               valid;
		logic               done;
		logic               hit;
		logic [ID_W-1:0]    vendor;
		logic [ID_W-1:0]    device;
		logic [CLASS_W-1:0] cls;
	} token_t;

endpackage

// ===== hw/rtl/didtm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// didtm_cell: one table entry and one step of the scan
// holds its entry, checks the passing query against it, hands it on
// ----------------------------------------------------------------------------
module didtm_cell #(
	parameter int unsigned CELL_INDEX = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load_en,
	input  logic [didtm_pkg::ENTRY_INDEX_W-1:0]  load_index,
	input  didtm_pkg::entry_t                    load_entry,
	input  didtm_pkg::token_t                    tok_in,
	output didtm_pkg::token_t                    tok_out
);
	import didtm_pkg::*;

	localparam logic HAS_SLOT = (CELL_INDEX < (1 << ENTRY_INDEX_W));
	localparam logic [ENTRY_INDEX_W-1:0] SLOT = CELL_INDEX[ENTRY_INDEX_W-1:0];

	entry_t entry_q;
	token_t tok_next;
	token_t tok_q;
	logic   tok_valid_q;
	logic   is_term;
	logic   is_match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (HAS_SLOT && load_en && (load_index == SLOT)) begin
			entry_q <= load_entry;
		end
	end

	always_comb begin
		is_term  = (entry_q.vendor == NULL_ID) && (entry_q.device == NULL_ID);
		is_match = ((entry_q.vendor == tok_in.vendor) || (entry_q.vendor == ANY_ID)) &&
		           ((entry_q.device == tok_in.device) || (entry_q.device == ANY_ID)) &&
		           ((entry_q.cls == tok_in.cls) || (entry_q.cls == ANY_CLASS));
		tok_next = tok_in;
		if (!tok_in.done) begin
			if (is_term) begin
				tok_next.done = 1'b1;
			end else if (is_match) begin
				tok_next.done = 1'b1;
				tok_next.hit  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_next;
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = tok_valid_q;
	end

endmodule

// ===== hw/rtl/device_id_table_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device_id_table_match: device ID table with a chained match scan
// a load transaction writes one entry; a query transaction walks the chain of
// entry cells and returns whether an entry before the terminator matched
// ----------------------------------------------------------------------------
// a query result is valid after the query has moved down the whole chain, one
//   entry cell per cycle, into the output register; a new query waits for it
// throughput: one load a cycle while no scan runs and no result waits
// reset: arst_n clears the whole table at once, so the table starts empty
//   and a query right after reset answers 0
module device_id_table_match #(
	parameter int unsigned TABLE_DEPTH = didtm_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// entry_index[3:0], entry_vendor[19:4], entry_device[35:20],
	// entry_class[59:36], dev_vendor[75:60], dev_device[91:76],
	// dev_class[99:92], dev_subclass[107:100], dev_interface[115:108]
	input  logic [119:0] s_axis_tdata,
	// kind[0]: 0 load, 1 query
	input  logic         s_axis_tuser,
	// result stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// matched[0]
	output logic [7:0]   m_axis_tdata
);
	import didtm_pkg::*;

	token_t chain [TABLE_DEPTH+1];
	logic   in_xfer;
	logic   load_en;
	entry_t load_entry;
	logic   busy_q;
	logic   out_valid_q;
	logic   matched_q;
	token_t last_tok;

	// one transaction in flight at a time, and only with the result taken
	assign s_axis_tready = !busy_q && !out_valid_q;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign load_en       = in_xfer && (kind_t'(s_axis_tuser) == KIND_LOAD);

	assign load_entry.vendor = s_axis_tdata[19:4];
	assign load_entry.device = s_axis_tdata[35:20];
	assign load_entry.cls    = s_axis_tdata[59:36];

	// query enters cell 0 in the cycle it is accepted
	always_comb begin
		chain[0].valid  = in_xfer && (kind_t'(s_axis_tuser) == KIND_QUERY);
		chain[0].done   = 1'b0;
		chain[0].hit    = 1'b0;
		chain[0].vendor = s_axis_tdata[75:60];
		chain[0].device = s_axis_tdata[91:76];
		chain[0].cls    = {s_axis_tdata[99:92], s_axis_tdata[107:100],
		                   s_axis_tdata[115:108]};
	end

	// row of entry cells, position 0 first
	for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
		didtm_cell #(
			.CELL_INDEX(gi)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load_en   (load_en),
			.load_index(s_axis_tdata[ENTRY_INDEX_W-1:0]),
			.load_entry(load_entry),
			.tok_in    (chain[gi]),
			.tok_out   (chain[gi+1])
		);
	end

	assign last_tok = chain[TABLE_DEPTH];

	// busy from query acceptance until the token leaves the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (chain[0].valid) begin
			busy_q <= 1'b1;
		end else if (last_tok.valid) begin
			busy_q <= 1'b0;
		end
	end

	// output register holds the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (last_tok.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last_tok.valid) begin
			matched_q <= last_tok.hit;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, matched_q};

endmodule

// ===== hw/rtl/didtm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// didtm_checker: port-level checks for the device ID table match
// watches the stream ports of the top level, bound in below
// ----------------------------------------------------------------------------
module didtm_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [119:0] s_axis_tdata,
	input logic         s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [7:0]   m_axis_tdata
);
	import didtm_pkg::*;

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// no new transaction taken while a result waits
	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input accepted with result pending");

	// a load never produces a result right behind it
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (kind_t'(s_axis_tuser) == KIND_LOAD)
		|=> !m_axis_tvalid)
		else $error("result after a load");

	// padding bits of the result stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'b0))
		else $error("nonzero result padding");

	// accepting a query drops input ready
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (kind_t'(s_axis_tuser) == KIND_QUERY)
		|=> !s_axis_tready)
		else $error("input ready during a scan");

endmodule

bind device_id_table_match didtm_checker u_didtm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

// ===== sim/device_id_table_match_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device_id_table_match_checker: scoreboard for the device ID table matcher
// keeps its own copy of the entry table, works out the expected answer of
// every accepted query and compares it with the result stream in order
// ----------------------------------------------------------------------------
module device_id_table_match_checker #(
	parameter int unsigned TABLE_DEPTH = didtm_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [119:0] s_axis_tdata,
	input  logic         s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [7:0]   m_axis_tdata,
	output int           mismatches,
	output int           answers_due
);
	import didtm_pkg::*;

	entry_t entry_copy [TABLE_DEPTH];
	bit     pending_answers [$];
	int     error_count = 0;

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		error_count++;
	endtask

	// scan from entry 0 until a terminator or the end of the table
	function automatic bit table_has_match(input logic [ID_W-1:0] vendor,
		input logic [ID_W-1:0] device, input logic [CLASS_W-1:0] cls);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (entry_copy[i].vendor == NULL_ID && entry_copy[i].device == NULL_ID)
				return 1'b0;
			if ((entry_copy[i].vendor == vendor || entry_copy[i].vendor == ANY_ID) &&
			    (entry_copy[i].device == device || entry_copy[i].device == ANY_ID) &&
			    (entry_copy[i].cls == cls || entry_copy[i].cls == ANY_CLASS))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [ENTRY_INDEX_W-1:0] idx;
		bit                       want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				entry_copy[i] = '0;
			pending_answers.delete();
		end else begin
			// results first: a result at this edge belongs to an older query
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_answers.size() == 0) begin
					report_mismatch($sformatf("result 0x%02h with no query waiting",
						m_axis_tdata));
				end else begin
					want = pending_answers.pop_front();
					if (m_axis_tdata !== {7'd0, want})
						report_mismatch($sformatf("matched: got 0x%02h, expected %0d",
							m_axis_tdata, want));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (kind_t'(s_axis_tuser) == KIND_LOAD) begin
					idx = s_axis_tdata[3:0];
					if (idx < TABLE_DEPTH) begin
						entry_copy[idx].vendor = s_axis_tdata[19:4];
						entry_copy[idx].device = s_axis_tdata[35:20];
						entry_copy[idx].cls    = s_axis_tdata[59:36];
					end
				end else begin
					pending_answers.push_back(table_has_match(s_axis_tdata[75:60],
						s_axis_tdata[91:76], {s_axis_tdata[99:92],
						s_axis_tdata[107:100], s_axis_tdata[115:108]}));
				end
			end
		end
		answers_due <= pending_answers.size();
		mismatches  <= error_count;
	end

endmodule

// ===== sim/device_id_table_match_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device_id_table_match_tb: stimulus and verdict for the device ID matcher
// loads table entries and sends queries through the input stream, with
// random gaps on both sides; the checker beside the block predicts and
// compares every answer
// ----------------------------------------------------------------------------
module device_id_table_match_tb;
	import didtm_pkg::*;

	localparam int unsigned DEPTH = DEFAULT_TABLE_DEPTH;
	// wait well past the time a query needs to pass through the chain
	localparam int unsigned SETTLE_CYCLES = 2 * (DEPTH + 2);
	localparam int unsigned HOLD_OFF_CYCLES = 300;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// entry_index[3:0], entry_vendor[19:4], entry_device[35:20],
	// entry_class[59:36], dev_vendor[75:60], dev_device[91:76],
	// dev_class[99:92], dev_subclass[107:100], dev_interface[115:108]
	logic [119:0] s_axis_tdata = '0;
	// kind[0]
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// matched[0]
	logic [7:0]   m_axis_tdata;

	int mismatches;
	int answers_due;

	// quiet: no gaps on either side; hold_req: receiver holds off for a while
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	// a few IDs that recur so random tables and queries actually hit
	logic [ID_W-1:0]    id_pool [4] = '{16'h1234, 16'h5678, ANY_ID, NULL_ID};
	logic [CLASS_W-1:0] class_pool [4] = '{24'h020000, 24'h0C0330, 24'hFFFFFF,
		24'h010601};

	always #5 clk = ~clk;

	device_id_table_match #(.TABLE_DEPTH(DEPTH)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	device_id_table_match_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.mismatches   (mismatches),
		.answers_due  (answers_due)
	);

	// mostly back to back or short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(0, 3) == 0)
			return ID_W'($urandom);
		return id_pool[$urandom_range(0, 3)];
	endfunction

	function automatic logic [CLASS_W-1:0] pick_class();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return ANY_CLASS;
		if (r < 8)
			return class_pool[$urandom_range(0, 3)];
		return CLASS_W'($urandom);
	endfunction

	// one transaction on the input stream, preceded by a random gap
	task automatic send_item(input kind_t kind, input logic [119:0] data);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= kind;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// query fields carry random noise on a load
	task automatic send_load(input logic [ENTRY_INDEX_W-1:0] idx,
		input logic [ID_W-1:0] vendor, input logic [ID_W-1:0] device,
		input logic [CLASS_W-1:0] cls);
		logic [55:0] noise;
		noise = 56'({$urandom, $urandom});
		send_item(KIND_LOAD, {4'd0, noise, cls, device, vendor, idx});
	endtask

	// entry fields carry random noise on a query; cls is class, subclass, interface
	task automatic send_query(input logic [ID_W-1:0] vendor,
		input logic [ID_W-1:0] device, input logic [CLASS_W-1:0] cls);
		logic [59:0] noise;
		noise = 60'({$urandom, $urandom});
		send_item(KIND_QUERY, {4'd0, cls[7:0], cls[15:8], cls[23:16], device,
			vendor, noise});
	endtask

	task automatic send_random_item();
		int r;
		logic [ENTRY_INDEX_W-1:0] idx;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			// raw noise on every bit but the top four, either kind
			send_item(kind_t'($urandom_range(0, 1)),
				{4'd0, 20'($urandom), {$urandom, $urandom, $urandom}});
		end else if (r < 50) begin
			// keep most loads in the first few entries so the scan gets past them
			idx = ($urandom_range(0, 9) < 7) ? ENTRY_INDEX_W'($urandom_range(0, 3)) :
				ENTRY_INDEX_W'($urandom_range(0, 15));
			send_load(idx, pick_id(), pick_id(), pick_class());
		end else begin
			send_query(pick_id(), pick_id(), pick_class());
		end
	endtask

	// answers_due is a registered count from the checker
	task automatic wait_for_answers();
		do
			@(posedge clk);
		while (answers_due != 0);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("device_id_table_match_tb: FAIL");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table right after reset, both extremes of the query fields
		send_query(16'h0000, 16'h0000, 24'h000000);
		send_query(16'hFFFF, 16'hFFFF, 24'hFFFFFF);

		// exact vendor and device, any class
		send_load(4'd0, 16'h8086, 16'h1234, ANY_CLASS);
		send_query(16'h8086, 16'h1234, 24'h0C0330);
		send_query(16'h8086, 16'h1235, 24'h0C0330);

		// any vendor and device, class must match
		send_load(4'd1, ANY_ID, ANY_ID, 24'h020000);
		send_query(16'h10EC, 16'h8168, 24'h020000);
		send_query(16'h10EC, 16'h8168, 24'h020001);

		// terminator with a nonzero class hides a match-all entry behind it
		send_load(4'd2, NULL_ID, NULL_ID, 24'hFFFFFF);
		send_load(4'd3, ANY_ID, ANY_ID, ANY_CLASS);
		send_query(16'h1AF4, 16'h1000, 24'h010000);

		// fill the whole table: no terminator, so the scan can reach the last entry;
		// zero vendor with nonzero device is a real entry, not a terminator
		for (int i = 2; i < DEPTH - 1; i++)
			send_load(ENTRY_INDEX_W'(i), NULL_ID, 16'(i), 24'(i << 8));
		send_load(ENTRY_INDEX_W'(DEPTH - 1), ANY_ID, NULL_ID, 24'hFFFFFF);
		send_query(16'h5555, 16'h0000, 24'hFFFFFF);
		send_query(16'h5555, 16'h0001, 24'hFFFFFF);
		send_query(16'h0000, 16'h0002, 24'h000200);

		// random traffic with gaps on both sides
		repeat (250) send_random_item();

		// receiver holds off while queries pour in, so the block backs up
		quiet = 1'b1;
		hold_req = 1'b1;
		repeat (12) send_query(pick_id(), pick_id(), pick_class());
		quiet = 1'b0;

		// sender pauses until every answer is back
		s_axis_tvalid <= 1'b0;
		wait_for_answers();
		@(posedge clk);

		// a stretch with no idling on either side
		quiet = 1'b1;
		repeat (150) send_random_item();
		quiet = 1'b0;

		repeat (230) send_random_item();
		s_axis_tvalid <= 1'b0;

		wait_for_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("device_id_table_match_tb: PASS");
		else
			$display("device_id_table_match_tb: FAIL");
		$finish;
	end

endmodule
